// File: hw/rtl/rv32_pkg.sv
// ----------------------------------------------------------------------------
// rv32_pkg: shared types and constants
// opcodes, csr addresses, decoded item and result types
// ----------------------------------------------------------------------------
package rv32_pkg;

	localparam int XLEN = 32;
	localparam int REG_COUNT = 32;
	localparam int RIDX_W = $clog2(REG_COUNT);
	localparam int QDEPTH = 2;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [31:0] W_EBREAK = 32'h0010_0073;
	localparam logic [31:0] W_ECALL  = 32'h0000_0073;
	localparam logic [31:0] W_MRET   = 32'h3020_0073;

	localparam logic [11:0] CSR_MSTATUS    = 12'h300;
	localparam logic [11:0] CSR_MTVEC      = 12'h305;
	localparam logic [11:0] CSR_ADDR_EPC   = 12'h341;
	localparam logic [11:0] CSR_ADDR_CAUSE = 12'h342;
	localparam logic [31:0] CAUSE_ECALL = 32'd11;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic [2:0] LK_NONE = 3'd0;
	localparam logic [2:0] LK_LB   = 3'd1;
	localparam logic [2:0] LK_LH   = 3'd2;
	localparam logic [2:0] LK_LW   = 3'd3;
	localparam logic [2:0] LK_LBU  = 3'd4;
	localparam logic [2:0] LK_LHU  = 3'd5;

	// item as classified by the front end
	typedef struct packed {
		logic        ld;
		logic [31:0] w;
		logic [31:0] pc;
		logic [31:0] ldata;
		logic        is_div;
	} item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [1:0]  mem_op;
		logic [31:0] mem_addr;
		logic [1:0]  mem_size;
		logic [31:0] mem_wdata;
		logic        halt;
		logic [31:0] halt_code;
		logic        illegal;
	} res_t;

endpackage

// File: hw/rtl/rv32_front.sv
// ----------------------------------------------------------------------------
// rv32_front: item intake
// classifies items and queues them for the back end
// ----------------------------------------------------------------------------
module rv32_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            func,
	input  logic [31:0]     instr_word,
	input  logic [31:0]     pc_in,
	input  logic [31:0]     load_data,
	output logic            q_valid,
	input  logic            q_ready,
	output rv32_pkg::item_t q_item
);
	import rv32_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	item_t          mem_q [QDEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;
	item_t          it;
	logic           push, pop;

	always_comb begin
		it.ld     = func;
		it.w      = instr_word;
		it.pc     = pc_in;
		it.ldata  = load_data;
		it.is_div = !func && instr_word[6:0] == OP_REG && instr_word[31:25] == 7'd1
			&& instr_word[14];
	end

	assign in_ready = cnt_q != (PW+1)'(QDEPTH);
	assign q_valid  = cnt_q != '0;
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/rv32_div.sv
// ----------------------------------------------------------------------------
// rv32_div: iterative divider
// unsigned restoring division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rv32_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	import rv32_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [31:0] q_q, r_q, d_q;
	logic [32:0] trial;

	assign trial = {r_q, q_q[31]} - {1'b0, d_q};
	assign quot  = q_q;
	assign rem   = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cnt_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend; r_q <= '0; d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0]; q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[30:0], q_q[31]}; q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

endmodule

// File: hw/rtl/rv32_back.sv
// ----------------------------------------------------------------------------
// rv32_back: execute back end
// register file, csrs, alu, multiplier and divider sequencing
// ----------------------------------------------------------------------------
module rv32_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  rv32_pkg::item_t q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output rv32_pkg::res_t  out_res
);
	import rv32_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t       st_q;
	logic [31:0]  rf_q [REG_COUNT];
	logic [31:0]  mstatus_q, mtvec_q, mepc_q, mcause_q;
	logic [RIDX_W-1:0] pdest_q;
	logic [2:0]   pkind_q;
	item_t        cur_q;
	res_t         res_q;
	logic [63:0]  prod_s1;
	logic [31:0]  a_q, b_q;
	logic         neg_q;

	logic [31:0] w, pc, seq, a, b, immi, imms, immb, immu, immj, csr_rd;
	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [4:0]  rd, rs1, rs2;
	logic        wr_en, ill, t;
	logic [31:0] wr_val;
	res_t        r;
	logic [2:0]  nkind;
	logic [4:0]  ndest;
	logic        csr_we, ecall;
	logic [32:0] ma, mb;
	logic [65:0] pfull;
	logic        dv_start, dv_done;
	logic [31:0] dv_q, dv_r, div_res;
	logic        sgn;
	logic [4:0]  wdst;
	logic        is_mul, commit;
	logic [31:0] qa, qb, dv_a_in, dv_b_in;
	logic        qs;

	assign w   = cur_q.w;
	assign pc  = cur_q.pc;
	assign seq = pc + 32'd4;
	assign op  = w[6:0];
	assign f3  = w[14:12];
	assign f7  = w[31:25];
	assign rd  = w[11:7];
	assign rs1 = w[19:15];
	assign rs2 = w[24:20];
	assign a   = (rs1 == 5'd0) ? 32'd0 : rf_q[rs1];
	assign b   = (rs2 == 5'd0) ? 32'd0 : rf_q[rs2];
	assign immi = {{20{w[31]}}, w[31:20]};
	assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
	assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	assign immu = {w[31:12], 12'd0};
	assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

	always_comb begin
		case (w[31:20])
			CSR_MSTATUS:    csr_rd = mstatus_q;
			CSR_MTVEC:      csr_rd = mtvec_q;
			CSR_ADDR_EPC:   csr_rd = mepc_q;
			CSR_ADDR_CAUSE: csr_rd = mcause_q;
			default:        csr_rd = 32'd0;
		endcase
	end

	// multiplier operands, sign-extended per variant
	assign ma = {(f3 == 3'd1 || f3 == 3'd2) && a[31], a};
	assign mb = {(f3 == 3'd1) && b[31], b};
	assign pfull = $signed(ma) * $signed(mb);

	// divider works on magnitudes, signs fixed on the way out
	assign sgn  = !f3[0];

	always_comb begin
		if (b_q == 32'd0)
			div_res = f3[1] ? a_q : 32'hffff_ffff;
		else if (f3[1])
			div_res = (sgn && a_q[31]) ? 32'd0 - dv_r : dv_r;
		else
			div_res = neg_q ? 32'd0 - dv_q : dv_q;
	end

	// combinational decode and execute of the current item
	always_comb begin
		r = '0; wr_en = 1'b0; wr_val = '0; ill = 1'b0; t = 1'b0;
		nkind = pkind_q; ndest = pdest_q; csr_we = 1'b0; ecall = 1'b0;
		if (cur_q.ld) begin
			wr_en = 1'b1;
			case (pkind_q)
				LK_LB:   wr_val = {{24{cur_q.ldata[7]}}, cur_q.ldata[7:0]};
				LK_LH:   wr_val = {{16{cur_q.ldata[15]}}, cur_q.ldata[15:0]};
				LK_LW:   wr_val = cur_q.ldata;
				LK_LBU:  wr_val = {24'd0, cur_q.ldata[7:0]};
				LK_LHU:  wr_val = {16'd0, cur_q.ldata[15:0]};
				default: wr_en = 1'b0;
			endcase
			if (wr_en) begin
				nkind = LK_NONE; ndest = '0;
			end
		end else begin
			r.next_pc = seq;
			case (op)
				OP_LUI:   begin wr_en = 1'b1; wr_val = immu; end
				OP_AUIPC: begin wr_en = 1'b1; wr_val = pc + immu; end
				OP_JAL:   begin wr_en = 1'b1; wr_val = seq; r.next_pc = pc + immj; end
				OP_JALR: begin
					if (f3 == 3'd0) begin
						wr_en = 1'b1; wr_val = seq; r.next_pc = (a + immi) & ~32'd1;
					end else ill = 1'b1;
				end
				OP_BRANCH: begin
					case (f3)
						3'd0: t = a == b;
						3'd1: t = a != b;
						3'd4: t = $signed(a) < $signed(b);
						3'd5: t = $signed(a) >= $signed(b);
						3'd6: t = a < b;
						3'd7: t = a >= b;
						default: ill = 1'b1;
					endcase
					if (t) r.next_pc = pc + immb;
				end
				OP_LOAD: begin
					if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
						r.mem_op = MEM_READ; r.mem_addr = a + immi; r.mem_size = f3[1:0];
						nkind = f3[2] ? f3 : f3 + 3'd1; ndest = rd;
					end else ill = 1'b1;
				end
				OP_STORE: begin
					if (f3 <= 3'd2) begin
						r.mem_op = MEM_WRITE; r.mem_addr = a + imms;
						r.mem_size = f3[1:0]; r.mem_wdata = b;
					end else ill = 1'b1;
				end
				OP_IMM: begin
					wr_en = 1'b1;
					case (f3)
						3'd0: wr_val = a + immi;
						3'd2: wr_val = {31'd0, $signed(a) < $signed(immi)};
						3'd3: wr_val = {31'd0, a < immi};
						3'd4: wr_val = a ^ immi;
						3'd6: wr_val = a | immi;
						3'd7: wr_val = a & immi;
						3'd1: begin
							if (f7 == 7'd0) wr_val = a << rs2;
							else begin ill = 1'b1; wr_en = 1'b0; end
						end
						default: begin
							if (f7 == 7'd0) wr_val = a >> rs2;
							else if (f7 == 7'h20) wr_val = $unsigned($signed(a) >>> rs2);
							else begin ill = 1'b1; wr_en = 1'b0; end
						end
					endcase
				end
				OP_REG: begin
					wr_en = 1'b1;
					if (f7 == 7'd0) begin
						case (f3)
							3'd0: wr_val = a + b;
							3'd1: wr_val = a << b[4:0];
							3'd2: wr_val = {31'd0, $signed(a) < $signed(b)};
							3'd3: wr_val = {31'd0, a < b};
							3'd4: wr_val = a ^ b;
							3'd5: wr_val = a >> b[4:0];
							3'd6: wr_val = a | b;
							default: wr_val = a & b;
						endcase
					end else if (f7 == 7'h20 && f3 == 3'd0) wr_val = a - b;
					else if (f7 == 7'h20 && f3 == 3'd5) wr_val = $unsigned($signed(a) >>> b[4:0]);
					else if (f7 == 7'd1) begin
						if (f3[2]) wr_val = div_res;
						else if (f3 == 3'd0) wr_val = prod_s1[31:0];
						else wr_val = prod_s1[63:32];
					end else begin ill = 1'b1; wr_en = 1'b0; end
				end
				OP_SYSTEM: begin
					if (w == W_EBREAK) begin
						r.halt = 1'b1; r.halt_code = rf_q[10];
					end else if (w == W_ECALL) begin
						ecall = 1'b1; r.next_pc = mtvec_q;
					end else if (f3 == 3'd1 && rd == 5'd0) csr_we = 1'b1;
					else if (f3 == 3'd2 && rs1 == 5'd0) begin
						wr_en = 1'b1; wr_val = csr_rd;
					end else if (w == W_MRET) r.next_pc = mepc_q;
					else ill = 1'b1;
				end
				default: ill = 1'b1;
			endcase
			if (ill) r.next_pc = seq;
			r.illegal = ill;
		end
	end

	assign wdst     = cur_q.ld ? pdest_q : rd;
	assign is_mul   = !cur_q.ld && op == OP_REG && f7 == 7'd1;
	assign q_ready  = st_q == ST_IDLE;
	assign dv_start = st_q == ST_IDLE && q_valid && q_item.is_div;
	assign out_valid = st_q == ST_OUT;
	assign out_res  = res_q;

	// commit: in ST_MUL for alu/mul items, on divider done for div items
	assign commit = (st_q == ST_MUL && !cur_q.is_div) || (st_q == ST_DIV && dv_done);

	// operand magnitudes for the divider come straight from the queued item
	assign qa = (q_item.w[19:15] == 5'd0) ? 32'd0 : rf_q[q_item.w[19:15]];
	assign qb = (q_item.w[24:20] == 5'd0) ? 32'd0 : rf_q[q_item.w[24:20]];
	assign qs = !q_item.w[12];
	assign dv_a_in = (qs && qa[31]) ? 32'd0 - qa : qa;
	assign dv_b_in = (qs && qb[31]) ? 32'd0 - qb : qb;

	rv32_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(q_item.is_div ? dv_a_in : 32'd0), .divisor(dv_b_in),
		.done(dv_done), .quot(dv_q), .rem(dv_r)
	);

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			cur_q <= q_item;
			a_q   <= qa;
			b_q   <= qb;
			neg_q <= qs && (qa[31] ^ qb[31]);
		end
		if (st_q == ST_MUL && is_mul) prod_s1 <= pfull[63:0];
		if (commit) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
			mstatus_q <= '0; mtvec_q <= '0; mepc_q <= '0; mcause_q <= '0;
			pdest_q <= '0; pkind_q <= LK_NONE;
		end else begin
			case (st_q)
				ST_IDLE: if (q_valid) st_q <= q_item.is_div ? ST_DIV : ST_MUL;
				ST_MUL:  st_q <= (is_mul && !cur_q.is_div) ? ST_DIV : ST_OUT;
				ST_DIV:  if (!cur_q.is_div || dv_done) st_q <= ST_OUT;
				ST_OUT:  if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			if (commit && !(st_q == ST_MUL && is_mul)) begin
				if (wr_en && wdst != 5'd0) rf_q[wdst] <= wr_val;
				pkind_q <= nkind; pdest_q <= ndest;
				if (ecall) begin
					mepc_q <= pc; mcause_q <= CAUSE_ECALL;
				end
				if (csr_we) begin
					case (w[31:20])
						CSR_MSTATUS:    mstatus_q <= a;
						CSR_MTVEC:      mtvec_q <= a;
						CSR_ADDR_EPC:   mepc_q <= a;
						CSR_ADDR_CAUSE: mcause_q <= a;
						default: ;
					endcase
				end
			end
			if (st_q == ST_DIV && !cur_q.is_div) begin
				if (wr_en && wdst != 5'd0) rf_q[wdst] <= wr_val;
			end
		end
	end

endmodule

// File: hw/rtl/rv32im_execute_unit_top.sv
// ----------------------------------------------------------------------------
// rv32im_execute_unit_top: rv32im execute unit
// front end queue feeding a sequenced execute back end
// ----------------------------------------------------------------------------
// usage
// - in channel: in_valid/in_ready with func, instr_word, pc_in, load_data;
//   func high delivers data for the pending load
// - out channel: out_valid/out_ready with one result item per input item
// - path from acceptance to a result: plain items go from the queue through
//   ST_MUL to ST_OUT, multiplies through ST_MUL and ST_DIV, div/rem wait in
//   ST_DIV for the divider, which yields one quotient bit per cycle
// - the back end holds one item at a time; a two-entry queue takes items
//   while the back end is busy or the receiver stalls
// - reset clears all registers, csrs and the pending load at once
// - a stalled receiver holds the result register; the queue fills, then
//   in_ready falls
// ----------------------------------------------------------------------------
module rv32im_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] instr_word,
	input  logic [31:0] pc_in,
	input  logic [31:0] load_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic [1:0]  mem_op,
	output logic [31:0] mem_addr,
	output logic [1:0]  mem_size,
	output logic [31:0] mem_wdata,
	output logic        halt,
	output logic [31:0] halt_code,
	output logic        illegal
);
	import rv32_pkg::*;

	// queue between front and back
	logic  q_valid, q_ready;
	item_t q_item;
	res_t  res;

	rv32_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .instr_word(instr_word), .pc_in(pc_in), .load_data(load_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	rv32_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign next_pc   = res.next_pc;
	assign mem_op    = res.mem_op;
	assign mem_addr  = res.mem_addr;
	assign mem_size  = res.mem_size;
	assign mem_wdata = res.mem_wdata;
	assign halt      = res.halt;
	assign halt_code = res.halt_code;
	assign illegal   = res.illegal;

	// a result never carries both a memory request and illegal
	a_ill_mem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> mem_op == MEM_NONE)
		else $error("illegal item issued a memory request");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("result changed while stalled");

	// back end takes no queued item while a result waits
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_ready)
		else $error("queue popped while result pending");

endmodule
